### design/assert_macros.svh
// assertion macros included by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FBPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FBPA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define FBPA_ASSERT(lbl, clk, rst_n, prop)
`define FBPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### design/fbpa_pkg.sv
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int BYTES_W    = 16;
    localparam int COUNT_W    = 9;
    localparam int OFFSET_W   = 24;
    localparam int CFG_DATA_W = 16;

    localparam logic [LINK_W-1:0]  LINK_END        = LINK_W'(MAX_BLOCKS);
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd64;
    localparam logic [COUNT_W-1:0] BLK_COUNT_RST   = 9'd256;
    localparam logic [IDX_W-1:0]   LAST_RST        = IDX_W'(MAX_BLOCKS - 1);

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic CFG_BLOCK_BYTES = 1'b0;
    localparam logic CFG_BLK_COUNT   = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              reinit;
        logic [IDX_W-1:0]  last;
    } t_link_req;

endpackage

### design/fbpa_link_store.sv
module fbpa_link_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbpa_pkg::t_link_req           i_req,
    output logic [fbpa_pkg::LINK_W-1:0]   o_link
);
    import fbpa_pkg::*;

    logic [LINK_W-1:0]     r_links [MAX_BLOCKS];
    logic [LINK_W-1:0]     r_rdata;
    logic [IDX_W-1:0]      r_rd_addr;
    logic                  r_rd_valid;
    logic [MAX_BLOCKS-1:0] r_valid;
    logic [IDX_W-1:0]      r_last;
    logic [IDX_W-1:0]      n_last;

    // link memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_links[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata   <= r_links[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // entries not written since reinit follow the default chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_last     <= LAST_RST;
            r_rd_valid <= 1'b0;
        end else begin
            r_last <= n_last;
            if (i_req.reinit) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    always_comb begin
        n_last = i_req.reinit ? i_req.last : r_last;
    end

    always_comb begin
        if (r_rd_valid) begin
            o_link = r_rdata;
        end else if (r_rd_addr == r_last) begin
            o_link = LINK_END;
        end else begin
            o_link = {1'b0, r_rd_addr} + LINK_W'(1);
        end
    end

endmodule

### design/fixed_block_pool_allocator_core.sv
// fixed-size block pool allocator with a linked free list
// input channel: i_valid / o_ready carry i_op and i_block_index; op alloc
// takes the head block, op free pushes an in-range i_block_index, op reinit rebuilds
// the list as blocks 0 up to the block count less one, in order
// output channel: o_valid / i_ready carry o_status, o_granted_index and
// o_block_offset, exactly one result per input transfer
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_index 0 for
// block_bytes and 1 for the block count; o_cfg_ready is always high
// results: a result is registered as the item leaves its execute state,
// which waits while the output register holds an untaken result; a new
// item is taken only in the idle state, since the head link must be read
// from the link memory before the head can move; reinit passes through
// the same states and clears the per-entry written flags of the link store
// reset: head at block 0, all 256 blocks chained, block_bytes 64,
// block count 256; o_ready is high in reset and from the first cycle after
// a stalled receiver holds the result in the output register; one more
// item may be taken and waits in its execute cycle until the slot frees
module fixed_block_pool_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_op,
    input  logic [fbpa_pkg::IDX_W-1:0]        i_block_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_status,
    output logic [fbpa_pkg::IDX_W-1:0]        o_granted_index,
    output logic [fbpa_pkg::OFFSET_W-1:0]     o_block_offset,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fbpa_pkg::*;
    `include "assert_macros.svh"

    localparam int PROD_W = IDX_W + BYTES_W + 1;

    t_state              r_state;
    t_state              n_state;
    logic [1:0]          r_op;
    logic [IDX_W-1:0]    r_idx;
    logic [LINK_W-1:0]   r_head;
    logic [LINK_W-1:0]   n_head;
    logic [BYTES_W-1:0]  r_block_bytes;
    logic [COUNT_W-1:0]  r_blk_count;
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [IDX_W-1:0]    r_granted;
    logic [OFFSET_W-1:0] r_offset;
    logic [1:0]          n_status;
    logic [IDX_W-1:0]    n_granted;
    logic [OFFSET_W-1:0] n_offset;

    logic                in_xfer;
    logic                out_free;
    logic                exec_go;
    logic                accepting;
    logic [COUNT_W-1:0]  eff_count;
    logic [BYTES_W:0]    stride;
    logic [PROD_W-1:0]   product;
    logic [LINK_W-1:0]   link;
    t_link_req           link_req;

    fbpa_link_store u_link_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (link_req),
        .o_link  (link)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_ready         = accepting;
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_block_offset  = r_offset;

    assign in_xfer  = i_valid && accepting;
    assign out_free = !r_out_valid || i_ready;

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        accepting = 1'b0;
        exec_go   = 1'b0;
        unique case (r_state)
            S_IDLE: accepting = 1'b1;
            S_EXEC: exec_go   = out_free;
        endcase
    end

    always_comb begin
        if (r_blk_count == '0) begin
            eff_count = COUNT_W'(1);
        end else if (r_blk_count > COUNT_W'(MAX_BLOCKS)) begin
            eff_count = COUNT_W'(MAX_BLOCKS);
        end else begin
            eff_count = r_blk_count;
        end
    end

    assign stride  = {1'b0, r_block_bytes} + (BYTES_W + 1)'(8);
    assign product = PROD_W'(r_head[IDX_W-1:0]) * PROD_W'(stride);

    always_comb begin
        link_req         = '0;
        link_req.rd_en   = in_xfer && (i_op == OP_ALLOC);
        link_req.rd_addr = r_head[IDX_W-1:0];
        link_req.wr_addr = r_idx;
        link_req.wr_data = r_head;
        link_req.last    = IDX_W'(eff_count - COUNT_W'(1));
        n_head    = r_head;
        n_status  = ST_OK;
        n_granted = '0;
        n_offset  = '0;
        unique case (r_op)
            OP_ALLOC: begin
                if (r_head[IDX_W]) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_granted = r_head[IDX_W-1:0];
                    n_offset  = OFFSET_W'(product + PROD_W'(8));
                    n_head    = link[IDX_W] ? LINK_END : link;
                end
            end
            OP_FREE: begin
                if ({1'b0, r_idx} >= eff_count) begin
                    n_status = ST_BAD_FREE;
                end else begin
                    link_req.wr_en = exec_go;
                    n_head         = {1'b0, r_idx};
                end
            end
            OP_REINIT: begin
                link_req.reinit = exec_go;
                n_head          = '0;
            end
            default: begin
                n_head = r_head;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_block_bytes <= BLOCK_BYTES_RST;
            r_blk_count   <= BLK_COUNT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data[BYTES_W-1:0];
                    CFG_BLK_COUNT:   r_blk_count   <= i_cfg_data[COUNT_W-1:0];
                endcase
            end
            if (exec_go) begin
                r_head      <= n_head;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op  <= i_op;
            r_idx <= i_block_index;
        end
        if (exec_go) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_offset  <= n_offset;
        end
    end

    `FBPA_ASSERT(a_head_range, i_clk, i_rst_n, r_head[IDX_W] |-> (r_head[IDX_W-1:0] == '0))
    `FBPA_ASSERT(a_xfer_to_exec, i_clk, i_rst_n, in_xfer |=> (r_state == S_EXEC))
    `FBPA_ASSERT(a_result_from_exec, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC))
    `FBPA_ASSERT(a_no_grant_on_error, i_clk, i_rst_n,
        (r_out_valid && (r_status != ST_OK)) |-> ((r_granted == '0) && (r_offset == '0)))
    `FBPA_ASSERT(a_one_mem_access, i_clk, i_rst_n, link_req.rd_en |-> !link_req.wr_en)

endmodule
